FILE: design/lc3bfd_pkg.sv
// Shared types, opcode codes and dependency mask bits for the LC-3b decoder.
package lc3bfd_pkg;

   typedef enum logic [3:0] {
      OP_BR   = 4'd0,
      OP_ADD  = 4'd1,
      OP_LDB  = 4'd2,
      OP_STB  = 4'd3,
      OP_JSR  = 4'd4,
      OP_AND  = 4'd5,
      OP_LDW  = 4'd6,
      OP_STW  = 4'd7,
      OP_RTI  = 4'd8,
      OP_XOR  = 4'd9,
      OP_RSV1 = 4'd10,
      OP_RSV2 = 4'd11,
      OP_JMP  = 4'd12,
      OP_SHF  = 4'd13,
      OP_LEA  = 4'd14,
      OP_TRAP = 4'd15
   } opcode_type;

   localparam logic [7:0] DM_DR  = 8'h01;
   localparam logic [7:0] DM_SR1 = 8'h02;
   localparam logic [7:0] DM_SR2 = 8'h04;
   localparam logic [7:0] DM_PC  = 8'h08;
   localparam logic [7:0] DM_RCC = 8'h10;
   localparam logic [7:0] DM_WCC = 8'h20;
   localparam logic [7:0] DM_RM  = 8'h40;
   localparam logic [7:0] DM_WM  = 8'h80;

   localparam logic [7:0] TRAP_GETC = 8'h20;
   localparam logic [7:0] TRAP_OUT  = 8'h21;
   localparam logic [7:0] TRAP_PUTS = 8'h22;

   typedef struct packed {
      logic [15:0] instr_word;
      logic [15:0] fetch_pc;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [2:0]  dest_reg;
      logic [2:0]  source_reg_a;
      logic [2:0]  source_reg_b;
      logic        uses_immediate;
      logic [15:0] immediate;
      logic [15:0] target_addr;
      logic [7:0]  dependency_mask;
      logic [15:0] next_pc;
      logic        bad_opcode;
   } rsp_payload_type;

endpackage

FILE: design/lc3bfd_channels.sv
// Valid/ready channel interfaces for decoder requests and responses.
interface lc3bfd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] instr_word;
   logic [15:0] fetch_pc;

   modport source (output valid, output instr_word, output fetch_pc, input ready);
   modport sink (input valid, input instr_word, input fetch_pc, output ready);
endinterface

interface lc3bfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  opcode;
   logic [2:0]  dest_reg;
   logic [2:0]  source_reg_a;
   logic [2:0]  source_reg_b;
   logic        uses_immediate;
   logic [15:0] immediate;
   logic [15:0] target_addr;
   logic [7:0]  dependency_mask;
   logic [15:0] next_pc;
   logic        bad_opcode;

   modport source (
      output valid, output opcode, output dest_reg, output source_reg_a,
      output source_reg_b, output uses_immediate, output immediate,
      output target_addr, output dependency_mask, output next_pc,
      output bad_opcode, input ready
   );
   modport sink (
      input valid, input opcode, input dest_reg, input source_reg_a,
      input source_reg_b, input uses_immediate, input immediate,
      input target_addr, input dependency_mask, input next_pc,
      input bad_opcode, output ready
   );
endinterface

FILE: design/lc3bfd_top.sv
// Top level of the LC-3b fetch decode stage: input register, decode, result register.
module lc3b_fetch_decode_top (
   input logic          clock,
   input logic          reset,
   lc3bfd_req_if.sink   req_ch,
   lc3bfd_rsp_if.source rsp_ch
);
   // Accepts one instruction item per clock while req ready is high and returns
   // one decoded item for each, in order. An item is captured in the input
   // register, decoded by a single pass of combinational logic (the pc+2 add
   // and one 16-bit add for the target, or for the JSR immediate) and then
   // registered in the result register, which drives rsp valid. One item per
   // cycle passes while rsp ready is not held low; the pipeline only holds when
   // the result register is full and rsp ready is low, and the input register
   // then keeps taking an item as long as it is empty.
   import lc3bfd_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_data_ff;
   rsp_payload_type dec_rsp;
   logic            out_free;
   logic            in_free;
   logic            move;

   lc3bfd_decode u_decode (
      .req (in_data_ff),
      .rsp (dec_rsp)
   );

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign move     = in_valid_ff && out_free;
   assign in_free  = !in_valid_ff || out_free;
   assign req_ch.ready = in_free;

   assign in_valid_in  = req_ch.valid ? 1'b1 : (in_valid_ff && !out_free);
   assign out_valid_in = move ? 1'b1 : (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_free) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
      if (in_free && req_ch.valid) begin
         in_data_ff.instr_word <= req_ch.instr_word;
         in_data_ff.fetch_pc   <= req_ch.fetch_pc;
      end
      if (move) begin
         out_data_ff <= dec_rsp;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.opcode          = out_data_ff.opcode;
   assign rsp_ch.dest_reg        = out_data_ff.dest_reg;
   assign rsp_ch.source_reg_a    = out_data_ff.source_reg_a;
   assign rsp_ch.source_reg_b    = out_data_ff.source_reg_b;
   assign rsp_ch.uses_immediate  = out_data_ff.uses_immediate;
   assign rsp_ch.immediate       = out_data_ff.immediate;
   assign rsp_ch.target_addr     = out_data_ff.target_addr;
   assign rsp_ch.dependency_mask = out_data_ff.dependency_mask;
   assign rsp_ch.next_pc         = out_data_ff.next_pc;
   assign rsp_ch.bad_opcode      = out_data_ff.bad_opcode;

endmodule

FILE: design/lc3bfd_decode.sv
// Combinational LC-3b instruction field decode and target arithmetic.
module lc3bfd_decode (
   input  lc3bfd_pkg::req_payload_type req,
   output lc3bfd_pkg::rsp_payload_type rsp
);
   import lc3bfd_pkg::*;

   logic [15:0] w;
   logic [15:0] pc2;
   logic [15:0] sext5;
   logic [15:0] sext6;
   logic [15:0] sext9;
   logic [15:0] sext11;
   logic [7:0]  vec;
   opcode_type  op;

   assign w      = req.instr_word;
   assign pc2    = req.fetch_pc + 16'd2;
   assign sext5  = {{11{w[4]}}, w[4:0]};
   assign sext6  = {{10{w[5]}}, w[5:0]};
   assign sext9  = {{7{w[8]}}, w[8:0]};
   assign sext11 = {{5{w[10]}}, w[10:0]};
   assign vec    = w[7:0];
   assign op     = opcode_type'(w[15:12]);

   always_comb begin
      rsp = '0;
      rsp.opcode  = w[15:12];
      rsp.next_pc = pc2;
      case (op)
         OP_ADD, OP_AND, OP_XOR: begin
            rsp.dest_reg       = w[11:9];
            rsp.source_reg_a   = w[8:6];
            rsp.uses_immediate = w[5];
            if (w[5]) begin
               rsp.immediate       = sext5;
               rsp.dependency_mask = DM_DR | DM_SR1 | DM_WCC;
            end else begin
               rsp.source_reg_b    = w[2:0];
               rsp.dependency_mask = DM_DR | DM_SR1 | DM_SR2 | DM_WCC;
            end
         end
         OP_BR: begin
            rsp.immediate       = {13'd0, w[11:9]};
            // branch offset is kept unshifted
            rsp.target_addr     = pc2 + sext9;
            rsp.dependency_mask = DM_PC | DM_RCC;
         end
         OP_JMP: begin
            rsp.source_reg_a    = w[8:6];
            rsp.dependency_mask = DM_SR1 | DM_PC;
         end
         OP_JSR: begin
            rsp.uses_immediate = w[11];
            if (w[11]) begin
               rsp.immediate       = pc2 + sext11;
               rsp.dependency_mask = DM_PC;
            end else begin
               rsp.source_reg_a    = w[8:6];
               rsp.dependency_mask = DM_PC | DM_SR1;
            end
         end
         OP_LDB, OP_LDW: begin
            rsp.dest_reg        = w[11:9];
            rsp.source_reg_a    = w[8:6];
            rsp.immediate       = sext6;
            rsp.dependency_mask = DM_DR | DM_SR1 | DM_RM | DM_WCC;
         end
         OP_LEA: begin
            rsp.dest_reg        = w[11:9];
            rsp.target_addr     = pc2 + {sext9[14:0], 1'b0};
            rsp.dependency_mask = DM_DR | DM_WCC;
         end
         OP_RTI: begin
            rsp.dependency_mask = DM_PC;
         end
         OP_SHF: begin
            rsp.dest_reg        = w[11:9];
            rsp.source_reg_a    = w[8:6];
            rsp.immediate       = {10'd0, w[5:0]};
            rsp.dependency_mask = DM_DR | DM_SR1 | DM_WCC;
         end
         OP_STB, OP_STW: begin
            // data register in 11..9, base in 8..6
            rsp.source_reg_a    = w[11:9];
            rsp.source_reg_b    = w[8:6];
            rsp.immediate       = sext6;
            rsp.dependency_mask = DM_SR1 | DM_SR2 | DM_WM;
         end
         OP_TRAP: begin
            rsp.immediate = {8'd0, vec};
            if (vec == TRAP_GETC) begin
               rsp.dependency_mask = DM_PC | DM_DR;
            end else if (vec == TRAP_OUT || vec == TRAP_PUTS) begin
               rsp.dependency_mask = DM_PC | DM_SR1;
            end else begin
               rsp.dependency_mask = DM_PC;
            end
         end
         default: begin
            rsp.bad_opcode = 1'b1;
         end
      endcase
   end

endmodule
